FILE: hw/rtl/mts_pkg.sv
// Shared types, codes and default sizes for the multi timer scheduler.
// No dependencies; used by every other file of the block but mts_ram.
package mts_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int MAX_RESULTS   = 16;

	localparam int FUNC_W     = 2;
	localparam int DELAY_W    = 31;
	localparam int PERIOD_W   = 31;
	localparam int ID_FIELD_W = 4;
	localparam int STATUS_W   = 3;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 8;

	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXPIRY  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic                accept;
		logic                add_pop;
		logic                add_load;
		logic                add_new;
		logic                add_wr;
		logic                rem;
		logic                tick_start;
		logic                scan_init;
		logic                scan_step;
		logic                upd;
		logic                emit;
		logic                emit_last;
		logic [STATUS_W-1:0] emit_code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic has_freed;
		logic ids_left;
		logic bad_id;
		logic scan_done;
		logic found;
		logic any_held;
		logic n_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hw/rtl/multi_timer_scheduler.sv
// Timer scheduler top, built from mts_ctrl and mts_dp; depends on mts_pkg. One word at a time.
// Per word: remove S_REM; add S_ADD, S_ADD_POP for a freed id, S_ADD_WR; full add S_ADD; then S_EMIT;
// the next word can be taken while the result waits in the output register.
// Tick: one scan of the timer RAM per expiry, then a closing scan that finds none;
// no closing scan once MAX_RESULTS expiries are counted; an empty tick ends after one scan.
// Reset clears time, pending bits and id counts; RAM data is only used after being written.
module multi_timer_scheduler #(
	parameter int SLOTS     = mts_pkg::SLOTS_DEF,
	parameter int TIME_BITS = mts_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mts_pkg::IN_TDATA_W-1:0]  s_tdata,  // delay, period, timer_id, zero pad
	input  logic [mts_pkg::FUNC_W-1:0]      s_tuser,  // func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mts_pkg::OUT_TDATA_W-1:0] m_tdata,  // slot_id, zero pad
	output logic [mts_pkg::STATUS_W-1:0]    m_tuser,  // status
	output logic                            m_tlast
);

	mts_pkg::cmd_t cmd;
	mts_pkg::sts_t sts;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mts_dp #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hw/rtl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/mts_ctrl.sv
// Sequencing state machine of the timer scheduler.
// Depends on mts_pkg; drives mts_dp through cmd_t, watches sts_t.
module mts_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic [mts_pkg::FUNC_W-1:0]   func,
	output logic                         s_tready,
	output mts_pkg::cmd_t                cmd,
	input  mts_pkg::sts_t                sts
);

	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_ADD        = 4'd1;
	localparam logic [3:0] S_ADD_POP    = 4'd2;
	localparam logic [3:0] S_ADD_WR     = 4'd3;
	localparam logic [3:0] S_REM        = 4'd4;
	localparam logic [3:0] S_EMIT       = 4'd5;
	localparam logic [3:0] S_TICK       = 4'd6;
	localparam logic [3:0] S_SCAN_START = 4'd7;
	localparam logic [3:0] S_SCAN       = 4'd8;
	localparam logic [3:0] S_DECIDE     = 4'd9;
	localparam logic [3:0] S_UPD        = 4'd10;
	localparam logic [3:0] S_FLUSH      = 4'd11;

	logic [3:0]                     state_q, state_d;
	logic [mts_pkg::STATUS_W-1:0]   code_q, code_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		code_d   = code_q;
		s_tready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					case (func)
						mts_pkg::FUNC_TICK:   state_d = S_TICK;
						mts_pkg::FUNC_ADD:    state_d = S_ADD;
						mts_pkg::FUNC_REMOVE: state_d = S_REM;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				code_d = mts_pkg::ST_ADDED;
				if (sts.has_freed) begin
					cmd.add_pop = 1'b1;
					state_d     = S_ADD_POP;
				end else if (sts.ids_left) begin
					cmd.add_new = 1'b1;
					state_d     = S_ADD_WR;
				end else begin
					code_d  = mts_pkg::ST_FULL;
					state_d = S_EMIT;
				end
			end
			S_ADD_POP: begin
				cmd.add_load = 1'b1;
				state_d      = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_EMIT;
			end
			S_REM: begin
				cmd.rem = 1'b1;
				code_d  = sts.bad_id ? mts_pkg::ST_BADID : mts_pkg::ST_REMOVED;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_code = code_q;
					state_d       = S_IDLE;
				end
			end
			S_TICK: begin
				cmd.tick_start = 1'b1;
				state_d        = S_SCAN_START;
			end
			S_SCAN_START: begin
				cmd.scan_init = 1'b1;
				state_d       = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// the previous expiry is only released once we know another follows
				if (sts.found) begin
					if (!sts.any_held) begin
						state_d = S_UPD;
					end else if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_code = mts_pkg::ST_EXPIRY;
						state_d       = S_UPD;
					end
				end else begin
					state_d = sts.any_held ? S_FLUSH : S_IDLE;
				end
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = sts.n_last ? S_FLUSH : S_SCAN_START;
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_code = mts_pkg::ST_EXPIRY;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= mts_pkg::ST_ADDED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

FILE: hw/rtl/mts_dp.sv
// Datapath of the timer scheduler: time count, timer and free-id stores,
// due scan and output register. Depends on mts_pkg and mts_ram.
module mts_dp #(
	parameter int SLOTS     = mts_pkg::SLOTS_DEF,
	parameter int TIME_BITS = mts_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [mts_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  mts_pkg::cmd_t                   cmd,
	output mts_pkg::sts_t                   sts,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mts_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [mts_pkg::STATUS_W-1:0]    m_tuser,
	output logic                            m_tlast
);

	localparam int ID_W    = $clog2(SLOTS);
	localparam int CNT_W   = ID_W + 1;
	localparam int WIDE_W  = ID_W + mts_pkg::ID_FIELD_W;
	localparam int SUM_W   = (TIME_BITS > mts_pkg::DELAY_W) ? TIME_BITS : mts_pkg::DELAY_W;
	localparam int ENTRY_W = mts_pkg::PERIOD_W + TIME_BITS;
	localparam int RES_W   = $clog2(mts_pkg::MAX_RESULTS + 1);
	localparam logic [TIME_BITS-1:0] TIME_TOP = {1'b1, {(TIME_BITS-1){1'b0}}};

	// latched request
	logic [mts_pkg::DELAY_W-1:0]    delay_q;
	logic [mts_pkg::PERIOD_W-1:0]   period_q;
	logic [mts_pkg::ID_FIELD_W-1:0] tid_q;

	logic [TIME_BITS-1:0] now_q;
	logic [SLOTS-1:0]     pending_q, done_q;
	logic [CNT_W-1:0]     freed_cnt_q, ids_used_q, scan_idx_q;
	logic [ID_W-1:0]      alloc_q;

	// scan pipeline and best candidate
	logic                          rd_v_s1;
	logic [ID_W-1:0]               rd_id_s1;
	logic                          found_q;
	logic [ID_W-1:0]               best_id_q, held_id_q;
	logic [TIME_BITS-1:0]          best_late_q, best_dl_q;
	logic [mts_pkg::PERIOD_W-1:0]  best_rl_q;
	logic [RES_W-1:0]              n_q;

	// output register
	logic                          m_tvalid_q;
	logic [mts_pkg::STATUS_W-1:0]  status_q;
	logic [mts_pkg::ID_FIELD_W-1:0] slot_q;
	logic                          last_q;

	// RAM ports
	logic                 t_we, t_re;
	logic [ID_W-1:0]      t_waddr;
	logic [ENTRY_W-1:0]   t_wdata, t_rdata;
	logic                 f_we;
	logic [ID_W-1:0]      f_wdata, f_rdata;
	logic [CNT_W-1:0]     freed_m1;

	logic [WIDE_W-1:0]    tid_wide;
	logic [ID_W-1:0]      tid_id;
	logic                 bad_id, out_free, rem_free, upd_free, push_ok;
	logic [TIME_BITS-1:0] add_dl, upd_dl, rd_dl, late;
	logic [mts_pkg::PERIOD_W-1:0] rd_rl;
	logic                 due, cand, take;
	logic [WIDE_W-1:0]    emit_wide;

	assign tid_wide = WIDE_W'(tid_q);
	assign tid_id   = tid_wide[ID_W-1:0];
	assign bad_id   = tid_wide >= WIDE_W'(ids_used_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign push_ok  = freed_cnt_q < CNT_W'(SLOTS);
	assign rem_free = cmd.rem && !bad_id && pending_q[tid_id];
	assign upd_free = cmd.upd && (best_rl_q == '0);
	assign freed_m1 = freed_cnt_q - 1'b1;

	assign add_dl = TIME_BITS'(SUM_W'(now_q) + SUM_W'(delay_q));
	assign upd_dl = TIME_BITS'(SUM_W'(best_dl_q) + SUM_W'(best_rl_q));

	// timer store: {reload, deadline}
	assign t_we    = cmd.add_wr || (cmd.upd && (best_rl_q != '0));
	assign t_waddr = cmd.add_wr ? alloc_q : best_id_q;
	assign t_wdata = cmd.add_wr ? {period_q, add_dl} : {best_rl_q, upd_dl};
	assign t_re    = cmd.scan_step && (scan_idx_q != CNT_W'(SLOTS));

	mts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_timer_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (scan_idx_q[ID_W-1:0]),
		.rdata (t_rdata)
	);

	// LIFO of freed ids
	assign f_we    = (rem_free || upd_free) && push_ok;
	assign f_wdata = cmd.rem ? tid_id : best_id_q;

	mts_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_freed_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (freed_cnt_q[ID_W-1:0]),
		.wdata (f_wdata),
		.re    (cmd.add_pop),
		.raddr (freed_m1[ID_W-1:0]),
		.rdata (f_rdata)
	);

	// due test: lateness in [0, half range] counts as due
	assign rd_dl = t_rdata[TIME_BITS-1:0];
	assign rd_rl = t_rdata[ENTRY_W-1:TIME_BITS];
	assign late  = now_q - rd_dl;
	assign due   = !late[TIME_BITS-1] || (late == TIME_TOP);
	assign cand  = rd_v_s1 && pending_q[rd_id_s1] && !done_q[rd_id_s1] && due;
	assign take  = cand && (!found_q || (late > best_late_q));

	// removes report the id as requested, even one beyond the slots in use
	always_comb begin
		case (cmd.emit_code)
			mts_pkg::ST_ADDED:   emit_wide = WIDE_W'(alloc_q);
			mts_pkg::ST_REMOVED: emit_wide = tid_wide;
			mts_pkg::ST_BADID:   emit_wide = tid_wide;
			mts_pkg::ST_EXPIRY:  emit_wide = WIDE_W'(held_id_q);
			default:             emit_wide = '0;
		endcase
	end

	always_comb begin
		sts           = '0;
		sts.has_freed = freed_cnt_q != '0;
		sts.ids_left  = ids_used_q < CNT_W'(SLOTS);
		sts.bad_id    = bad_id;
		sts.scan_done = (scan_idx_q == CNT_W'(SLOTS)) && !rd_v_s1;
		sts.found     = found_q;
		sts.any_held  = n_q != '0;
		sts.n_last    = n_q == RES_W'(mts_pkg::MAX_RESULTS - 1);
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			pending_q   <= '0;
			done_q      <= '0;
			freed_cnt_q <= '0;
			ids_used_q  <= '0;
			scan_idx_q  <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			n_q         <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.add_pop) begin
				freed_cnt_q <= freed_m1;
			end else if (f_we) begin
				freed_cnt_q <= freed_cnt_q + 1'b1;
			end
			if (cmd.add_new) begin
				ids_used_q <= ids_used_q + 1'b1;
			end
			if (cmd.add_wr) begin
				pending_q[alloc_q] <= 1'b1;
			end
			if (rem_free) begin
				pending_q[tid_id] <= 1'b0;
			end
			if (upd_free) begin
				pending_q[best_id_q] <= 1'b0;
			end
			if (cmd.tick_start) begin
				now_q  <= now_q + 1'b1;
				done_q <= '0;
				n_q    <= '0;
			end
			if (cmd.upd) begin
				done_q[best_id_q] <= 1'b1;
				n_q               <= n_q + 1'b1;
			end
			if (cmd.scan_init) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				rd_v_s1    <= 1'b0;
			end else begin
				rd_v_s1 <= t_re;
				if (t_re) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			delay_q  <= s_tdata[mts_pkg::DELAY_W-1:0];
			period_q <= s_tdata[mts_pkg::DELAY_W+mts_pkg::PERIOD_W-1:mts_pkg::DELAY_W];
			tid_q    <= s_tdata[mts_pkg::DELAY_W+mts_pkg::PERIOD_W+mts_pkg::ID_FIELD_W-1:
				mts_pkg::DELAY_W+mts_pkg::PERIOD_W];
		end
		if (cmd.add_new) begin
			alloc_q <= ids_used_q[ID_W-1:0];
		end else if (cmd.add_load) begin
			alloc_q <= f_rdata;
		end
		if (t_re) begin
			rd_id_s1 <= scan_idx_q[ID_W-1:0];
		end
		if (take && !cmd.scan_init) begin
			best_id_q   <= rd_id_s1;
			best_late_q <= late;
			best_dl_q   <= rd_dl;
			best_rl_q   <= rd_rl;
		end
		if (cmd.upd) begin
			held_id_q <= best_id_q;
		end
		if (cmd.emit) begin
			status_q <= cmd.emit_code;
			slot_q   <= emit_wide[mts_pkg::ID_FIELD_W-1:0];
			last_q   <= cmd.emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = mts_pkg::OUT_TDATA_W'(slot_q);
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result loaded over an untaken word");

	a_freed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		freed_cnt_q <= ids_used_q)
		else $error("more freed ids than ids handed out");

	a_alloc_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |-> (CNT_W'(alloc_q) < ids_used_q))
		else $error("timer armed in a slot never handed out");

	a_upd_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> found_q && !done_q[best_id_q])
		else $error("expiry update without a fresh due timer");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_timer_scheduler: command words in, status words out.
// Predicts each word's outcomes in-bench and checks them in order; needs mts_pkg and the RTL.
module testbench;

	import mts_pkg::*;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int TARGET_WORDS = 120;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 400;

	typedef struct {
		logic [FUNC_W-1:0]     fn;
		logic [DELAY_W-1:0]    dly;
		logic [PERIOD_W-1:0]   per;
		logic [ID_FIELD_W-1:0] tid;
		bit                    settle;  // hold back until every outcome is in
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ID_FIELD_W-1:0] slot;
		logic                  last;
	} outcome_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [FUNC_W-1:0]      s_tuser = FUNC_TICK;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   m_tlast;

	multi_timer_scheduler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	request_t request_q[$];
	outcome_t outcome_q[$];

	int queued_cmds = 0;   // words other than the ignored func
	int total_words = 0;
	int n_sent = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_expiry = 0;
	int n_full = 0;
	int n_badid = 0;
	int errors = 0;
	int clk_cycles = 0;
	bit quiet = 1'b0;

	// timer state as the block should hold it
	logic [TIME_BITS_DEF-1:0] clock_now;
	logic [TIME_BITS_DEF-1:0] due_time[SLOTS];
	logic [PERIOD_W-1:0]      reload_ticks[SLOTS];
	bit                       armed[SLOTS];
	logic [ID_FIELD_W-1:0]    free_ids[SLOTS];
	int                       free_top;
	int                       ids_issued;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void push_req(input logic [FUNC_W-1:0] fn, input logic [DELAY_W-1:0] dly,
			input logic [PERIOD_W-1:0] per, input logic [ID_FIELD_W-1:0] tid, input bit settle);
		request_t r;
		r.fn = fn;
		r.dly = dly;
		r.per = per;
		r.tid = tid;
		r.settle = settle;
		request_q.insert(request_q.size(), r);
		if (fn != FUNC_NONE)
			queued_cmds++;
	endfunction

	function automatic void push_outcome(input logic [STATUS_W-1:0] st,
			input logic [ID_FIELD_W-1:0] slot, input logic last);
		outcome_t o;
		o.status = st;
		o.slot = slot;
		o.last = last;
		outcome_q.insert(outcome_q.size(), o);
	endfunction

	function automatic void release_id(input logic [ID_FIELD_W-1:0] id);
		if (free_top < SLOTS) begin
			free_ids[free_top] = id;
			free_top++;
		end
	endfunction

	// Work out the outcomes of one accepted command word and update the timer state.
	function automatic void schedule_outcomes(input logic [FUNC_W-1:0] fn,
			input logic [DELAY_W-1:0] dly, input logic [PERIOD_W-1:0] per,
			input logic [ID_FIELD_W-1:0] tid);
		logic [ID_FIELD_W-1:0]    id;
		logic [TIME_BITS_DEF-1:0] gap;
		logic [TIME_BITS_DEF-1:0] late;
		logic [TIME_BITS_DEF-1:0] best_late;
		bit                       done[SLOTS];
		int                       best;
		int                       n;
		case (fn)
			FUNC_ADD: begin
				if (free_top > 0) begin
					free_top--;
					id = free_ids[free_top];
				end else if (ids_issued < SLOTS) begin
					id = ids_issued[ID_FIELD_W-1:0];
					ids_issued++;
				end else begin
					push_outcome(ST_FULL, '0, 1'b1);
					return;
				end
				due_time[id] = clock_now + {1'b0, dly};
				reload_ticks[id] = per;
				armed[id] = 1'b1;
				push_outcome(ST_ADDED, id, 1'b1);
			end
			FUNC_REMOVE: begin
				if (tid >= ids_issued) begin
					push_outcome(ST_BADID, tid, 1'b1);
				end else begin
					// removing an idle id is acknowledged but changes nothing
					if (armed[tid]) begin
						armed[tid] = 1'b0;
						release_id(tid);
					end
					push_outcome(ST_REMOVED, tid, 1'b1);
				end
			end
			FUNC_TICK: begin
				clock_now = clock_now + 1'b1;
				for (int s = 0; s < SLOTS; s++)
					done[s] = 1'b0;
				n = 0;
				while (n < MAX_RESULTS) begin
					best = -1;
					best_late = '0;
					for (int s = 0; s < SLOTS; s++) begin
						gap = due_time[s] - clock_now;
						if (armed[s] && !done[s] && (gap == '0 || gap[TIME_BITS_DEF-1])) begin
							late = clock_now - due_time[s];
							// strict compare keeps ties on the lower id
							if (best < 0 || late > best_late) begin
								best = s;
								best_late = late;
							end
						end
					end
					if (best < 0)
						break;
					done[best] = 1'b1;
					if (reload_ticks[best] != '0) begin
						due_time[best] = due_time[best] + {1'b0, reload_ticks[best]};
					end else begin
						armed[best] = 1'b0;
						release_id(best[ID_FIELD_W-1:0]);
					end
					push_outcome(ST_EXPIRY, best[ID_FIELD_W-1:0], 1'b0);
					n++;
				end
				if (n > 0)
					outcome_q[outcome_q.size()-1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	function automatic void report(input string what, input outcome_t want, input outcome_t got);
		errors++;
		if (errors <= 10)
			$display({"%0t: %s: expected status %0d slot %0d last %0b, ",
				"got status %0d slot %0d last %0b"},
				$realtime, what, want.status, want.slot, want.last, got.status, got.slot, got.last);
	endfunction

	// Stimulus: directed words first, then random command sequences.
	initial begin : stimulus
		int reps;
		int kind;
		for (int s = 0; s < SLOTS; s++) begin
			armed[s] = 1'b0;
			due_time[s] = '0;
			reload_ticks[s] = '0;
			free_ids[s] = '0;
		end
		clock_now = '0;
		free_top = 0;
		ids_issued = 0;

		push_req(FUNC_REMOVE, '0, '0, 4'd0, 1'b0);                 // nothing issued yet: bad id
		push_req(FUNC_TICK, '0, '0, '0, 1'b0);                      // empty tick
		push_req(FUNC_ADD, '0, '0, '0, 1'b0);                       // zero delay one-shot
		push_req(FUNC_TICK, '0, '0, '0, 1'b0);                      // fires, id freed
		push_req(FUNC_ADD, '1, '1, '1, 1'b0);                       // reuses freed id, all ones
		push_req(FUNC_ADD, 31'd2, 31'd1, '0, 1'b0);
		push_req(FUNC_ADD, 31'd2, '0, '0, 1'b0);
		push_req(FUNC_TICK, '1, '1, '1, 1'b0);
		push_req(FUNC_TICK, '0, '0, '0, 1'b0);                      // tie: lower id first
		push_req(FUNC_TICK, '0, '0, '0, 1'b0);                      // period of one fires again
		push_req(FUNC_REMOVE, '0, '0, 4'd2, 1'b0);                  // idle id
		push_req(FUNC_REMOVE, '0, '0, 4'd1, 1'b0);
		push_req(FUNC_REMOVE, '1, '1, 4'd15, 1'b0);                 // beyond ids issued
		push_req(FUNC_NONE, '1, '1, '1, 1'b0);                      // unused func, ignored
		push_req(FUNC_REMOVE, '0, '0, 4'd0, 1'b0);                  // cancels the far timer
		push_req(FUNC_ADD, 31'h2AAAAAAA, 31'h55555555, 4'h5, 1'b0);
		push_req(FUNC_TICK, '0, '0, '0, 1'b1);

		// fill every slot until adds are refused
		for (int k = 0; k < SLOTS + 2; k++)
			push_req(FUNC_ADD, DELAY_W'($urandom_range(1000, 32'h7FFFFFFF)),
				PERIOD_W'($urandom), ID_FIELD_W'($urandom), 1'b0);
		for (int k = 0; k < SLOTS; k++)
			push_req(FUNC_REMOVE, DELAY_W'($urandom), PERIOD_W'($urandom),
				ID_FIELD_W'($urandom_range(0, 15)), 1'b0);

		while (queued_cmds < TARGET_WORDS) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// arm a few short timers and run the clock
				reps = $urandom_range(1, 4);
				for (int k = 0; k < reps; k++)
					push_req(FUNC_ADD,
						DELAY_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6)),
						PERIOD_W'(($urandom_range(0, 9) == 0) ? $urandom :
							(($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 5))),
						ID_FIELD_W'($urandom), ($urandom_range(0, 19) == 0));
				reps = $urandom_range(1, 8);
				for (int k = 0; k < reps; k++)
					push_req(FUNC_TICK, DELAY_W'($urandom), PERIOD_W'($urandom),
						ID_FIELD_W'($urandom), 1'b0);
				if ($urandom_range(0, 1))
					push_req(FUNC_REMOVE, DELAY_W'($urandom), PERIOD_W'($urandom),
						ID_FIELD_W'($urandom_range(0, 15)), 1'b0);
			end else if (kind < 65) begin
				for (int k = 0; k < SLOTS + 1; k++)
					push_req(FUNC_ADD, DELAY_W'($urandom_range(0, 40)),
						PERIOD_W'($urandom_range(0, 3)), ID_FIELD_W'($urandom), 1'b0);
				for (int k = 0; k < 4; k++)
					push_req(FUNC_TICK, DELAY_W'($urandom), PERIOD_W'($urandom),
						ID_FIELD_W'($urandom), 1'b0);
			end else if (kind < 85) begin
				reps = $urandom_range(1, 5);
				for (int k = 0; k < reps; k++)
					push_req(($urandom_range(0, 1)) ? FUNC_REMOVE : FUNC_TICK,
						DELAY_W'($urandom), PERIOD_W'($urandom),
						ID_FIELD_W'($urandom_range(0, 15)), 1'b0);
			end else begin
				// noise: any func, any content
				push_req(FUNC_W'($urandom_range(0, 3)), DELAY_W'($urandom),
					PERIOD_W'($urandom), ID_FIELD_W'($urandom), 1'b0);
			end
		end
		total_words = request_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(n_taken == total_words && outcome_q.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d command words and %0d results: %0d expiries, %0d full, %0d bad ids.",
			n_taken, n_checked, n_expiry, n_full, n_badid);
		if (errors == 0 && outcome_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d results never seen", errors, outcome_q.size());
			$display("FAIL");
		end
		$finish;
	end

	// Sender: one word at a time, random gaps between words.
	always @(negedge clk) begin : driver
		int gap_left;
		request_t r;
		if (arst_n) begin
			quiet = (n_taken >= total_words - 25);
			if (s_tvalid && n_taken != n_sent) begin
				// word still on offer
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_q.size() != 0 &&
					!(request_q[0].settle && outcome_q.size() != 0)) begin
				r = request_q.pop_front();
				s_tdata <= {{(IN_TDATA_W-DELAY_W-PERIOD_W-ID_FIELD_W){1'b0}}, r.tid, r.per, r.dly};
				s_tuser <= r.fn;
				s_tvalid <= 1'b1;
				n_sent++;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end else begin
			gap_left = 0;
		end
	end

	// Receiver: random stalls, and one long hold-off to back the block up.
	always @(negedge clk) begin : receiver
		int stall_left;
		int hold_left;
		bit held;
		if (!arst_n) begin
			stall_left = 0;
			hold_left = 0;
			held = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!held && n_taken >= 40) begin
			held = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 11) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: check result words, predict on accepted command words.
	always @(posedge clk) begin : monitor
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.slot = m_tdata[ID_FIELD_W-1:0];
				got.last = m_tlast;
				n_checked++;
				if (got.status == ST_EXPIRY)
					n_expiry++;
				if (got.status == ST_FULL)
					n_full++;
				if (got.status == ST_BADID)
					n_badid++;
				if (outcome_q.size() == 0) begin
					report("unexpected result", '0, got);
				end else begin
					want = outcome_q.pop_front();
					if (got.status !== want.status || got.slot !== want.slot ||
							got.last !== want.last)
						report("mismatch", want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				schedule_outcomes(s_tuser, s_tdata[DELAY_W-1:0],
					s_tdata[DELAY_W+PERIOD_W-1:DELAY_W],
					s_tdata[DELAY_W+PERIOD_W+ID_FIELD_W-1:DELAY_W+PERIOD_W]);
				n_taken++;
			end
		end
	end

	always @(posedge clk) begin
		clk_cycles++;
		if (clk_cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d of %0d words taken, %0d results outstanding",
				clk_cycles, n_taken, total_words, outcome_q.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule
